// ===== rtl/wpc_pkg.sv =====
// wpc_pkg: shared widths, action codes and defaults for the waveform
// playback and capture block
// no dependencies; compiled first
package wpc_pkg;

  localparam int ACTION_W       = 2;
  localparam int INDEX_W        = 7;
  localparam int WORD_W         = 16;
  localparam int RING_DEPTH_DEF = 128;

  // action codes carried by an input word
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } action_t;

endpackage

// ===== rtl/wpc_if.sv =====
// wpc_cmd_if, wpc_res_if: valid/ready channels for command and result words
// depends on wpc_pkg
interface wpc_cmd_if
  import wpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  word_index;
  logic [WORD_W-1:0]   sample_word;
  logic [WORD_W-1:0]   input_adc_word;
  logic [WORD_W-1:0]   output_adc_word;

  modport source (output valid, action, word_index, sample_word, input_adc_word,
                  output_adc_word, input ready);
  modport sink   (input valid, action, word_index, sample_word, input_adc_word,
                  output_adc_word, output ready);
endinterface

interface wpc_res_if
  import wpc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  dac_word;
  logic [WORD_W-1:0]  captured_input;
  logic [WORD_W-1:0]  captured_output;
  logic [INDEX_W-1:0] play_position;

  modport source (output valid, dac_word, captured_input, captured_output,
                  play_position, input ready);
  modport sink   (input valid, dac_word, captured_input, captured_output,
                  play_position, output ready);
endinterface

// ===== rtl/wpc_ram.sv =====
// wpc_ram: generic single-write, single-read memory with registered read data
// no dependencies
module wpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/waveform_playback_capture_top.sv =====
// waveform_playback_capture_top: ring-buffer waveform player with two-channel
// capture; depends on wpc_pkg, wpc_if (wpc_cmd_if, wpc_res_if) and wpc_ram
//
// usage
//   cmd    : command words in (valid/ready). action load writes sample_word at
//            word_index, tick plays the sample under the play pointer and stores
//            both converter words there, read returns the captured pair at
//            word_index. every command word yields exactly one result word.
//   result : result words out (valid/ready): dac_word, captured_input,
//            captured_output, play_position.
//   cfg    : cfg_wr_en/cfg_wr_data write play_length (0 = whole ring); write it
//            only while no command is in flight.
// timing
//   one command word per cycle while the result channel takes results. a result
//   passes through the registered read port of the sample and capture memories,
//   then through the result register.
// reset
//   rst clears the play pointer, play_length and both pipeline valids, and
//   holds cmd.ready low. memory contents are not cleared; entries are
//   meaningful only once written.
// stalls
//   while the result register is held, one more word waits in the memory read
//   stage; only then does cmd.ready drop, so no word is lost or repeated.
module waveform_playback_capture_top
  import wpc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_wr_data,
  wpc_cmd_if.sink            cmd,
  wpc_res_if.source          result
);

  localparam int AW    = $clog2(RING_DEPTH);
  // compare width: holds both RING_DEPTH and any play_length value
  localparam int CW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int IDX_N = 2 ** INDEX_W;

  // word_index wraps modulo the ring depth; built by counting, no divider
  function automatic logic [IDX_N*AW-1:0] wrap_table();
    logic [IDX_N*AW-1:0] tbl;
    int                  r;
    tbl = '0;
    r   = 0;
    for (int i = 0; i < IDX_N; i++) begin
      tbl[i*AW +: AW] = AW'(r);
      r = (r == RING_DEPTH - 1) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam logic [IDX_N*AW-1:0] WRAP_TABLE = wrap_table();

  // configuration and pointer state
  logic [INDEX_W-1:0] play_length;
  logic [AW-1:0]      play_pointer;
  logic [AW-1:0]      play_pointer_next;

  // memory read stage
  logic               s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic [INDEX_W-1:0] s1_pos;

  // result register
  logic               res_valid;
  logic [WORD_W-1:0]  res_dac;
  logic [WORD_W-1:0]  res_cin;
  logic [WORD_W-1:0]  res_cout;
  logic [INDEX_W-1:0] res_pos;

  // datapath
  logic                cmd_accept;
  logic                s1_move;
  logic                is_tick;
  logic                is_load;
  logic                is_read;
  logic [AW-1:0]       word_addr;
  logic [CW-1:0]       len_eff;
  logic [AW-1:0]       ptr_eff;
  logic [INDEX_W-1:0]  pos_report;
  logic [WORD_W-1:0]   sample_q;
  logic [2*WORD_W-1:0] capture_q;

  // the read stage advances when the result register is empty or being taken
  assign s1_move    = !res_valid || result.ready;
  assign cmd.ready  = !rst && (!s1_valid || s1_move);
  assign cmd_accept = cmd.valid && cmd.ready;

  assign is_load = (cmd.action == ACT_LOAD);
  assign is_tick = (cmd.action == ACT_TICK);
  assign is_read = (cmd.action == ACT_READ);

  assign word_addr = WRAP_TABLE[cmd.word_index*AW +: AW];

  // effective ring length: zero or anything past the ring means the whole ring
  always_comb begin
    if (play_length == '0 || CW'(play_length) > CW'(RING_DEPTH)) begin
      len_eff = CW'(RING_DEPTH);
    end else begin
      len_eff = CW'(play_length);
    end
  end

  // pointer returns to the start once it reaches the length, then advances
  assign ptr_eff = (CW'(play_pointer) >= len_eff) ? '0 : play_pointer;
  assign play_pointer_next = (ptr_eff == AW'(RING_DEPTH - 1)) ? '0 : ptr_eff + 1'b1;

  // reported position: the entry used on a tick, else the current pointer
  assign pos_report = is_tick ? INDEX_W'(ptr_eff) : INDEX_W'(play_pointer);

  // sample ring: written by load, read by tick
  wpc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_sample_ram (
    .clk     (clk),
    .wr_en   (cmd_accept && is_load),
    .wr_addr (word_addr),
    .wr_data (cmd.sample_word),
    .rd_en   (cmd_accept && is_tick),
    .rd_addr (ptr_eff),
    .rd_data (sample_q)
  );

  // capture store holds {input word, output word}: written by tick, read by read
  wpc_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_capture_ram (
    .clk     (clk),
    .wr_en   (cmd_accept && is_tick),
    .wr_addr (ptr_eff),
    .wr_data ({cmd.input_adc_word, cmd.output_adc_word}),
    .rd_en   (cmd_accept && is_read),
    .rd_addr (word_addr),
    .rd_data (capture_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_length  <= '0;
      play_pointer <= '0;
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        play_length <= cfg_wr_data;
      end
      if (cmd_accept && is_tick) begin
        play_pointer <= play_pointer_next;
      end
      if (cmd.ready) begin
        s1_valid <= cmd.valid;
      end
      if (s1_move) begin
        res_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      s1_action <= cmd.action;
      s1_pos    <= pos_report;
    end
    if (s1_valid && s1_move) begin
      res_pos  <= s1_pos;
      res_dac  <= (s1_action == ACT_TICK) ? sample_q : '0;
      res_cin  <= (s1_action == ACT_READ) ? capture_q[2*WORD_W-1:WORD_W] : '0;
      res_cout <= (s1_action == ACT_READ) ? capture_q[WORD_W-1:0] : '0;
    end
  end

  assign result.valid           = res_valid;
  assign result.dac_word        = res_dac;
  assign result.captured_input  = res_cin;
  assign result.captured_output = res_cout;
  assign result.play_position   = res_pos;

  // the pointer never leaves the ring
  a_ptr_in_ring: assert property (@(posedge clk) disable iff (rst)
    CW'(play_pointer) < CW'(RING_DEPTH))
    else $error("play pointer outside the ring");

  // back-pressure only when both the read stage and the result register are full
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && res_valid && !result.ready))
    else $error("cmd stalled with room in the pipeline");

  // only an accepted tick moves the pointer
  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !(cmd_accept && is_tick) |=> $stable(play_pointer))
    else $error("play pointer moved without a tick");

  // after a tick the pointer is at most the effective length
  a_ptr_after_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd_accept && is_tick) |=> CW'(play_pointer) <= $past(len_eff))
    else $error("play pointer ran past the ring length");

  // a result only appears from a word held in the read stage
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid))
    else $error("result without a word in the read stage");

endmodule

// ===== bench/wpc_playback_checker.sv =====
`timescale 1ns / 1ps
// wpc_playback_checker: predicts every result word of the waveform playback block
// and compares it field by field with the result channel; depends on wpc_pkg and
// the wpc_cmd_if / wpc_res_if channels
module wpc_playback_checker
  import wpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_wr_data,
  wpc_cmd_if                 cmd,
  wpc_res_if                 result,
  output int                 fail_count,
  output int                 outstanding
);

  localparam int DEPTH = RING_DEPTH_DEF;

  typedef struct packed {
    logic [WORD_W-1:0]  dac_word;
    logic [WORD_W-1:0]  captured_input;
    logic [WORD_W-1:0]  captured_output;
    logic [INDEX_W-1:0] play_position;
  } playback_word_t;

  logic [WORD_W-1:0]  wave_mem    [DEPTH];
  logic [WORD_W-1:0]  in_cap_mem  [DEPTH];
  logic [WORD_W-1:0]  out_cap_mem [DEPTH];
  int unsigned        play_ptr;
  logic [INDEX_W-1:0] play_len;
  playback_word_t     owed_words[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    play_ptr    = 0;
    play_len    = '0;
    foreach (wave_mem[i]) begin
      wave_mem[i]    = '0;
      in_cap_mem[i]  = '0;
      out_cap_mem[i] = '0;
    end
  end

  task automatic flag_word(string msg);
    $display("%0t ns  %s", $realtime, msg);
    fail_count++;
  endtask

  // applies one command word to the ring and returns the word it owes
  function automatic playback_word_t advance_player(
    logic [ACTION_W-1:0] act,
    logic [INDEX_W-1:0]  idx,
    logic [WORD_W-1:0]   sample_val,
    logic [WORD_W-1:0]   in_adc,
    logic [WORD_W-1:0]   out_adc
  );
    playback_word_t w;
    int unsigned    ring;
    int unsigned    slot;
    int unsigned    pos;
    w    = '0;
    slot = idx % DEPTH;
    pos  = play_ptr;
    case (act)
      ACT_LOAD: wave_mem[slot] = sample_val;
      ACT_TICK: begin
        ring = (play_len == 0 || play_len > DEPTH) ? DEPTH : play_len;
        if (play_ptr >= ring) play_ptr = 0;
        pos              = play_ptr;
        in_cap_mem[pos]  = in_adc;
        out_cap_mem[pos] = out_adc;
        w.dac_word       = wave_mem[pos];
        play_ptr         = (pos + 1) % DEPTH;
      end
      ACT_READ: begin
        w.captured_input  = in_cap_mem[slot];
        w.captured_output = out_cap_mem[slot];
      end
      default: ;
    endcase
    w.play_position = INDEX_W'(pos);
    return w;
  endfunction

  always @(posedge clk) begin
    playback_word_t got;
    playback_word_t want;
    if (rst) begin
      owed_words.delete();
      play_ptr = 0;
      play_len = '0;
    end else begin
      if (result.valid && result.ready) begin
        got.dac_word        = result.dac_word;
        got.captured_input  = result.captured_input;
        got.captured_output = result.captured_output;
        got.play_position   = result.play_position;
        if (owed_words.size() == 0) begin
          flag_word($sformatf("result word with nothing owed: %h", got));
        end else begin
          want = owed_words.pop_front();
          if (got.dac_word !== want.dac_word)
            flag_word($sformatf("dac_word %h, want %h", got.dac_word, want.dac_word));
          if (got.captured_input !== want.captured_input)
            flag_word($sformatf("captured_input %h, want %h",
                                got.captured_input, want.captured_input));
          if (got.captured_output !== want.captured_output)
            flag_word($sformatf("captured_output %h, want %h",
                                got.captured_output, want.captured_output));
          if (got.play_position !== want.play_position)
            flag_word($sformatf("play_position %0d, want %0d",
                                got.play_position, want.play_position));
        end
      end
      // a word taken at the same edge as a length write still sees the old length
      if (cmd.valid && cmd.ready)
        owed_words.push_back(advance_player(cmd.action, cmd.word_index, cmd.sample_word,
                                            cmd.input_adc_word, cmd.output_adc_word));
      if (cfg_wr_en) play_len = cfg_wr_data;
    end
    outstanding = owed_words.size();
  end

endmodule

// ===== bench/waveform_playback_capture_top_tb.sv =====
`timescale 1ns / 1ps
// waveform_playback_capture_top_tb: drives command words and random back-pressure
// into the waveform playback block; depends on wpc_pkg, wpc_if and wpc_playback_checker
module waveform_playback_capture_top_tb;
  import wpc_pkg::*;

  localparam int                  DEPTH       = RING_DEPTH_DEF;
  localparam int                  CYCLE_LIMIT = 400000;
  localparam int                  PHASE_WORDS = 225;
  localparam int                  PHASES      = 8;
  // the action code the block has no use for
  localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [INDEX_W-1:0] cfg_wr_data;
  int                 fail_count;
  int                 outstanding;
  int unsigned        cycle_count = 0;
  bit                 quiet_tail;

  // stimulus side view of the ring, only to keep every played entry loaded
  // and every read entry captured
  bit                 loaded   [DEPTH];
  bit                 captured [DEPTH];
  int unsigned        gen_ptr;
  int unsigned        gen_len;

  // per phase ring length and tick share in percent
  int                 phase_len  [PHASES];
  int                 phase_tick [PHASES];

  wpc_cmd_if cmd_ch ();
  wpc_res_if res_ch ();

  waveform_playback_capture_top #(
    .RING_DEPTH (DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .result      (res_ch)
  );

  wpc_playback_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .result      (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("waveform_playback_capture_top verification failed");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts, none in the tail
  initial begin
    res_ch.ready = 1'b1;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  // entry the next tick will use, after the return to 0 past the ring length
  function automatic int unsigned next_slot();
    int unsigned ring;
    ring = (gen_len == 0) ? DEPTH : gen_len;
    return (gen_ptr >= ring) ? 0 : gen_ptr;
  endfunction

  // offers one command word and returns at the edge that accepts it;
  // valid stays high afterwards so back-to-back words need no reassert
  task automatic push_word(logic [ACTION_W-1:0] act, int unsigned idx,
                           logic [WORD_W-1:0] sample_val, logic [WORD_W-1:0] in_adc,
                           logic [WORD_W-1:0] out_adc);
    bit          took;
    int unsigned slot;
    if (act == ACT_LOAD) begin
      loaded[idx % DEPTH] = 1'b1;
    end else if (act == ACT_TICK) begin
      slot           = next_slot();
      captured[slot] = 1'b1;
      gen_ptr        = (slot + 1) % DEPTH;
    end
    // sender gap burst
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.action          <= act;
    cmd_ch.word_index      <= INDEX_W'(idx);
    cmd_ch.sample_word     <= sample_val;
    cmd_ch.input_adc_word  <= in_adc;
    cmd_ch.output_adc_word <= out_adc;
    // ready is settled by the falling edge, so sample it there
    do begin
      @(negedge clk);
      took = cmd_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // stop sending and hold until every owed result word is back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // ring length change, only with the block idle
  task automatic set_length(int unsigned len);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= INDEX_W'(len);
    gen_len      = len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // one random word; ticks onto an unloaded entry, and reads while no entry is
  // captured, are turned into a load of the entry the player needs next
  task automatic random_word(int tick_pct, int load_pct);
    int          roll;
    int unsigned slot;
    int unsigned idx;
    roll = $urandom_range(0, 99);
    slot = next_slot();
    if (roll < 3) begin
      push_word(ACT_UNUSED, $urandom_range(0, DEPTH - 1), rand_word(), rand_word(),
                rand_word());
    end else if (roll < 3 + tick_pct) begin
      if (loaded[slot])
        push_word(ACT_TICK, $urandom_range(0, DEPTH - 1), rand_word(), rand_word(),
                  rand_word());
      else
        push_word(ACT_LOAD, slot, rand_word(), rand_word(), rand_word());
    end else if (roll < 3 + tick_pct + load_pct) begin
      // half the loads land where the player is about to go
      idx = $urandom_range(0, 1) ? slot : $urandom_range(0, DEPTH - 1);
      push_word(ACT_LOAD, idx, rand_word(), rand_word(), rand_word());
    end else begin
      // scan forward from a random start for a captured entry
      idx = $urandom_range(0, DEPTH - 1);
      repeat (DEPTH) if (!captured[idx]) idx = (idx + 1) % DEPTH;
      if (captured[idx])
        push_word(ACT_READ, idx, rand_word(), rand_word(), rand_word());
      else
        push_word(ACT_LOAD, slot, rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    cmd_ch.valid           = 1'b0;
    cmd_ch.action          = ACT_LOAD;
    cmd_ch.word_index      = '0;
    cmd_ch.sample_word     = '0;
    cmd_ch.input_adc_word  = '0;
    cmd_ch.output_adc_word = '0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    rst                    = 1'b1;
    quiet_tail             = 1'b0;
    gen_ptr                = 0;
    gen_len                = 0;
    foreach (loaded[i]) begin
      loaded[i]   = 1'b0;
      captured[i] = 1'b0;
    end
    phase_len  = '{0, 127, 1, 0, 2, $urandom_range(3, 126), 127, 0};
    phase_tick = '{55, 45, 35, 60, 40, 45, 50, 60};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every action, whole ring after reset
    push_word(ACT_LOAD, 0, 16'hffff, 16'h0000, 16'h0000);
    push_word(ACT_LOAD, DEPTH - 1, 16'h0000, 16'hffff, 16'hffff);
    push_word(ACT_LOAD, 1, 16'h8001, 16'h0000, 16'h0000);
    push_word(ACT_LOAD, 64, 16'h7ffe, 16'h0000, 16'h0000);
    push_word(ACT_TICK, 0, 16'h0000, 16'hffff, 16'h0000);
    push_word(ACT_TICK, DEPTH - 1, 16'hffff, 16'h0000, 16'hffff);
    push_word(ACT_READ, 0, 16'h0000, 16'h0000, 16'h0000);
    push_word(ACT_READ, 1, 16'hffff, 16'hffff, 16'hffff);
    // unused action code leaves everything alone
    push_word(ACT_UNUSED, DEPTH - 1, 16'hffff, 16'hffff, 16'hffff);
    push_word(ACT_UNUSED, 0, 16'h0000, 16'h0000, 16'h0000);
    push_word(ACT_LOAD, 2, 16'h5aa5, 16'h0000, 16'h0000);
    push_word(ACT_TICK, 0, 16'h0000, 16'ha55a, 16'h5aa5);
    push_word(ACT_READ, 2, 16'h0000, 16'h0000, 16'h0000);

    // shrink the ring below the pointer: the next tick starts over at 0
    set_length(2);
    push_word(ACT_TICK, 0, 16'h0000, 16'h1234, 16'h4321);
    push_word(ACT_TICK, 0, 16'h0000, 16'hfedc, 16'hcdef);
    push_word(ACT_TICK, 0, 16'h0000, 16'h0f0f, 16'hf0f0);
    // one-word ring replays the same entry
    set_length(1);
    push_word(ACT_TICK, 0, 16'h0000, 16'h00ff, 16'hff00);
    push_word(ACT_TICK, 0, 16'h0000, 16'hff00, 16'h00ff);
    push_word(ACT_READ, 0, 16'h0000, 16'h0000, 16'h0000);
    push_word(ACT_READ, 1, 16'h0000, 16'h0000, 16'h0000);

    // random phases, one ring length each
    for (int p = 0; p < PHASES; p++) begin
      set_length(phase_len[p]);
      if (p == PHASES - 1) quiet_tail = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // sender holds off mid-phase until every owed word is back
        if (p == 2 && n == PHASE_WORDS / 2) drain();
        random_word(phase_tick[p], 20);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("waveform_playback_capture_top verification clean");
    end else begin
      $display("waveform_playback_capture_top verification failed");
    end
    $finish;
  end

endmodule
